// ----- rtl/core/script_token_lexer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the script token lexer
// Concurrent check macros that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_LEXER_CORE_ASSERT_SVH
`define SCRIPT_TOKEN_LEXER_CORE_ASSERT_SVH

`ifndef SYNTH

// A condition that must hold at every clock edge outside reset.
`define STL_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lexer check failed: condition does not hold");

// A condition that must hold in the cycle after its trigger.
`define STL_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("lexer check failed: next-cycle condition does not hold");

`else

`define STL_ASSERT_ALWAYS(label, clk, rst, cond)
`define STL_ASSERT_NEXT(label, clk, rst, trig, cond)

`endif

`endif

// ----- rtl/core/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// Script token lexer package
// Types, character codes and the per-byte lexing function.
// ----------------------------------------------------------------------------
package stl_pkg;

  // Lexer mode, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_SLASH   = 6'b000010,
    MODE_COMMENT = 6'b000100,
    MODE_STRING  = 6'b001000,
    MODE_NAME    = 6'b010000,
    MODE_STOPPED = 6'b100000
  } mode_t;

  // Token classes.
  localparam logic [2:0] CLS_EOF     = 3'd0;
  localparam logic [2:0] CLS_DIVIDE  = 3'd1;
  localparam logic [2:0] CLS_COMMENT = 3'd2;
  localparam logic [2:0] CLS_EOL     = 3'd3;
  localparam logic [2:0] CLS_OPEN    = 3'd4;
  localparam logic [2:0] CLS_CLOSE   = 3'd5;
  localparam logic [2:0] CLS_STRING  = 3'd6;
  localparam logic [2:0] CLS_NAME    = 3'd7;

  // Event kinds.
  localparam logic EV_CHAR = 1'b0;
  localparam logic EV_END  = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Result queue geometry.
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One result beat.
  typedef struct packed {
    logic       kind;
    logic [2:0] cls;
    logic [7:0] ch;
    logic       last;
  } result_t;

  // Outcome of handling a byte from the idle mode.
  typedef struct packed {
    logic    emit;
    result_t r;
    mode_t   mode;
  } idle_t;

  // Outcome of one input beat: up to two results and the next mode.
  typedef struct packed {
    mode_t      mode;
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_t;

  function automatic result_t mk_result(logic kind, logic [2:0] cls, logic [7:0] ch);
    result_t r;
    r.kind = kind;
    r.cls  = cls;
    r.ch   = ch;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic is_name_char(logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_SLASH) ||
           (c == CH_UNDER) || (c == CH_DOT);
  endfunction

  // Handle a byte with the lexer between tokens.
  function automatic idle_t from_idle(logic [7:0] c);
    idle_t o;
    o.emit = 1'b0;
    o.r    = mk_result(EV_END, CLS_EOF, CH_NUL);
    o.mode = MODE_IDLE;
    if (!is_blank(c)) begin
      unique case (c)
        CH_NUL: begin
          o.emit = 1'b1;
          o.mode = MODE_STOPPED;
        end
        CH_SLASH:  o.mode = MODE_SLASH;
        CH_NL: begin
          o.emit = 1'b1;
          o.r    = mk_result(EV_END, CLS_EOL, CH_NUL);
        end
        CH_LBRACE: begin
          o.emit = 1'b1;
          o.r    = mk_result(EV_END, CLS_OPEN, CH_NUL);
        end
        CH_RBRACE: begin
          o.emit = 1'b1;
          o.r    = mk_result(EV_END, CLS_CLOSE, CH_NUL);
        end
        CH_QUOTE:  o.mode = MODE_STRING;
        default: begin
          o.emit = 1'b1;
          o.r    = mk_result(EV_CHAR, CLS_NAME, c);
          o.mode = MODE_NAME;
        end
      endcase
    end
    return o;
  endfunction

  // Full per-beat lexing step.
  function automatic step_t lex_step(mode_t mode, logic [7:0] c, logic eos);
    step_t s;
    idle_t id;
    s.mode = mode;
    s.n    = 2'd0;
    s.r0   = mk_result(EV_END, CLS_EOF, CH_NUL);
    s.r1   = mk_result(EV_END, CLS_EOF, CH_NUL);
    id     = from_idle(c);
    if (mode != MODE_STOPPED) begin
      if (eos) begin
        s.n    = 2'd1;
        s.mode = MODE_STOPPED;
      end else begin
        unique case (mode)
          MODE_IDLE: begin
            s.n    = {1'b0, id.emit};
            s.r0   = id.r;
            s.mode = id.mode;
          end
          MODE_SLASH: begin
            if (is_blank(c)) begin
              s.n    = 2'd1;
              s.r0   = mk_result(EV_END, CLS_DIVIDE, CH_NUL);
              s.mode = MODE_IDLE;
            end else if (c == CH_SLASH) begin
              s.mode = MODE_COMMENT;
            end else begin
              s.n    = 2'd1;
              s.r0   = mk_result(EV_CHAR, CLS_NAME, c);
              s.mode = MODE_NAME;
            end
          end
          MODE_COMMENT: begin
            if (c == CH_NL) begin
              s.n    = 2'd1;
              s.r0   = mk_result(EV_END, CLS_COMMENT, CH_NUL);
              s.mode = MODE_IDLE;
            end
          end
          MODE_STRING: begin
            s.n = 2'd1;
            if (c == CH_QUOTE) begin
              s.r0   = mk_result(EV_END, CLS_STRING, CH_NUL);
              s.mode = MODE_IDLE;
            end else begin
              s.r0 = mk_result(EV_CHAR, CLS_STRING, c);
            end
          end
          MODE_NAME: begin
            if (is_name_char(c)) begin
              s.n  = 2'd1;
              s.r0 = mk_result(EV_CHAR, CLS_NAME, c);
            end else begin
              // The name ends, then the byte is handled again from idle.
              s.n    = id.emit ? 2'd2 : 2'd1;
              s.r0   = mk_result(EV_END, CLS_NAME, CH_NUL);
              s.r1   = id.r;
              s.mode = id.mode;
            end
          end
          default: begin
            // Codes that are not one-hot act as stopped.
            s.n    = 2'd0;
            s.mode = MODE_STOPPED;
          end
        endcase
      end
    end
    // Mark the final result of this beat.
    if (s.n == 2'd1) begin
      s.r0.last = 1'b1;
    end
    if (s.n == 2'd2) begin
      s.r1.last = 1'b1;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/script_token_lexer_core.sv -----
// ----------------------------------------------------------------------------
// Script token lexer core
// Byte-stream lexer for brace-structured entity script text.
// ----------------------------------------------------------------------------
// The block takes one byte of script text per input beat and emits token
// characters followed by an end-of-token beat that carries the token class.
// Each input beat is decoded combinationally against the registered lexer
// mode and yields zero, one or two result beats, which enter a four-entry
// result queue; the input is ready whenever the queue has room for two
// results, so bytes are taken one per cycle while the output keeps pace, and
// the sustained rate is bounded by the single output beat per cycle. After an
// end-of-file token the lexer ignores all input until reset.
// ----------------------------------------------------------------------------
`include "script_token_lexer_core_assert.svh"

module script_token_lexer_core (
  input  logic       clk,
  input  logic       rst,
  // Input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] source_byte
  input  logic [0:0] s_tuser,   // [0] end_of_source
  // Result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] text_char
  output logic [3:0] m_tuser,   // [0] event_kind, [3:1] token_class
  output logic       m_tlast    // last result of the input beat
);

  localparam int QDEPTH = 1 << stl_pkg::QPTR_W;

  stl_pkg::mode_t   mode;
  stl_pkg::step_t   step;
  stl_pkg::result_t queue [QDEPTH];

  logic [stl_pkg::QPTR_W-1:0] head;
  logic [stl_pkg::QPTR_W-1:0] tail;
  logic [stl_pkg::QPTR_W-1:0] tail_p1;
  logic [stl_pkg::QCNT_W-1:0] count;
  logic [1:0]                 push_n;
  logic                       s_fire;
  logic                       m_fire;
  logic                       is_stopped;

  // Decode the incoming beat against the current mode.
  always_comb begin
    step = stl_pkg::lex_step(mode, s_tdata, s_tuser[0]);
  end

  // Handshakes: accept while two queue slots are free.
  assign s_tready = (count <= stl_pkg::QCNT_W'(QDEPTH - 2));
  assign s_fire   = s_tvalid & s_tready;
  assign m_tvalid = (count != '0);
  assign m_fire   = m_tvalid & m_tready;
  assign push_n   = s_fire ? step.n : 2'd0;
  assign tail_p1  = tail + stl_pkg::QPTR_W'(1);

  // Mode and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= stl_pkg::MODE_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (s_fire) begin
        mode <= step.mode;
      end
      head  <= head + stl_pkg::QPTR_W'(m_fire);
      tail  <= tail + stl_pkg::QPTR_W'(push_n);
      count <= count + stl_pkg::QCNT_W'(push_n) - stl_pkg::QCNT_W'(m_fire);
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[tail] <= step.r0;
    end
    if (push_n == 2'd2) begin
      queue[tail_p1] <= step.r1;
    end
  end

  // Present the head of the queue.
  assign m_tdata = queue[head].ch;
  assign m_tuser = {queue[head].cls, queue[head].kind};
  assign m_tlast = queue[head].last;

  // Checks.
  assign is_stopped = (mode == stl_pkg::MODE_STOPPED);

  `STL_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= stl_pkg::QCNT_W'(QDEPTH))
  `STL_ASSERT_NEXT(a_stop_sticks, clk, rst, is_stopped, is_stopped)
  `STL_ASSERT_ALWAYS(a_stopped_silent, clk, rst, !is_stopped || (step.n == 2'd0))

endmodule
